[rtl/core/swd_pkg.sv]
// Shared types, constants and helper functions for the swerve drive kinematics block.
package swd_pkg;

    localparam int CMD_W   = 11;
    localparam int THR_W   = 11;
    localparam int SCALE_W = 16;
    localparam int CFG_W   = 16;
    localparam int XY_W    = 29;
    localparam int SPEED_W = 16;
    localparam int ANGLE_W = 15;
    localparam int WHEELS  = 4;

    localparam logic [THR_W-1:0]   THR_RESET   = 11'd50;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd852;

    localparam logic [16:0] HALF_SQRT2_Q16 = 17'd46341;

    // Front end stages (deadband, tangent product, wheel vectors) and lane stages.
    localparam int FRONT_STAGES = 3;
    localparam int LANE_STAGES  = 18;
    localparam int LATENCY      = FRONT_STAGES + LANE_STAGES;

    typedef logic signed [XY_W-1:0] coord_t;

    typedef enum logic {
        REG_DEADBAND = 1'b0,
        REG_SCALE    = 1'b1
    } cfg_reg_t;

    // Sign of the unit tangent of each wheel, x and y parts.
    function automatic logic tan_x_neg(input int wheel);
        return (wheel == 1) || (wheel == 2);
    endfunction

    function automatic logic tan_y_neg(input int wheel);
        return (wheel == 2) || (wheel == 3);
    endfunction

endpackage

[rtl/core/swd_speed.sv]
// Wheel speed lane: squared length, pipelined integer square root, scaling.
module swd_speed
    import swd_pkg::*;
(
    input  logic                 clk,
    input  coord_t               x,
    input  coord_t               y,
    input  logic [SCALE_W-1:0]   scale,
    output logic [SPEED_W-1:0]   speed
);

    localparam int SQ_W     = 56;
    localparam int ROOT_W   = 28;
    localparam int SQ_PER   = 2;
    localparam int SQ_STG   = ROOT_W / SQ_PER;
    localparam logic [SQ_W-1:0] SQ_TOP = SQ_W'(1) << (2 * (ROOT_W - 1));

    logic [SQ_W-1:0] sqx_reg;
    logic [SQ_W-1:0] sqy_reg;
    logic [SQ_W-1:0] sum_reg;
    logic [SQ_W-1:0] rem_reg [SQ_STG];
    logic [SQ_W-1:0] res_reg [SQ_STG];
    logic [ROOT_W+SCALE_W-1:0] prod_reg;
    logic [SPEED_W-1:0] speed_reg;

    logic [ROOT_W-1:0] ax;
    logic [ROOT_W-1:0] ay;

    assign ax = ROOT_W'(x < 0 ? -x : x);
    assign ay = ROOT_W'(y < 0 ? -y : y);

    always_ff @(posedge clk)
    begin
        sqx_reg <= SQ_W'(ax) * SQ_W'(ax);
        sqy_reg <= SQ_W'(ay) * SQ_W'(ay);
        sum_reg <= sqx_reg + sqy_reg;
    end

    genvar s;
    generate
        for (s = 0; s < SQ_STG; s++)
        begin : g_root
            logic [SQ_W-1:0] rem_in;
            logic [SQ_W-1:0] res_in;
            logic [SQ_W-1:0] rem_next;
            logic [SQ_W-1:0] res_next;

            if (s == 0)
            begin : g_first
                assign rem_in = sum_reg;
                assign res_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign res_in = res_reg[s-1];
            end

            always_comb
            begin
                logic [SQ_W-1:0] trial;
                logic [SQ_W-1:0] b;
                rem_next = rem_in;
                res_next = res_in;
                for (int j = 0; j < SQ_PER; j++)
                begin
                    b     = SQ_TOP >> (2 * (s * SQ_PER + j));
                    trial = res_next + b;
                    if (rem_next >= trial)
                    begin
                        rem_next = rem_next - trial;
                        res_next = (res_next >> 1) + b;
                    end
                    else
                    begin
                        res_next = res_next >> 1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s] <= rem_next;
                res_reg[s] <= res_next;
            end
        end
    endgenerate

    logic [ROOT_W+SCALE_W-1:0] rounded;
    logic [ROOT_W+SCALE_W-25:0] shifted;

    assign rounded = prod_reg + (ROOT_W+SCALE_W)'(1 << 23);
    assign shifted = rounded[ROOT_W+SCALE_W-1:24];

    always_ff @(posedge clk)
    begin
        prod_reg <= (ROOT_W+SCALE_W)'(res_reg[SQ_STG-1][ROOT_W-1:0])
                    * (ROOT_W+SCALE_W)'(scale);
        if (shifted > (ROOT_W+SCALE_W-24)'(16'hFFFF))
            speed_reg <= '1;
        else
            speed_reg <= shifted[SPEED_W-1:0];
    end

    assign speed = speed_reg;

endmodule

[rtl/core/swd_cordic.sv]
// Steering angle lane: quadrant fold and one CORDIC vectoring step per stage.
module swd_cordic
    import swd_pkg::*;
(
    input  logic                       clk,
    input  coord_t                     x,
    input  coord_t                     y,
    output logic signed [ANGLE_W-1:0]  angle
);

    localparam int STEPS = 16;
    localparam int CW    = 32;
    localparam int ZW    = 20;
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [ZW-1:0] PI_Q12      = 20'sd12868;

    localparam logic [16:0] ATAN_Q16 [STEPS] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047,
        17'd1024, 17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16,
        17'd8, 17'd4, 17'd2
    };

    logic signed [CW-1:0] x_reg [STEPS+1];
    logic signed [CW-1:0] y_reg [STEPS+1];
    logic signed [ZW-1:0] z_reg [STEPS+1];
    logic                 zero_reg [STEPS+1];
    logic signed [ANGLE_W-1:0] angle_reg;

    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;

    assign xe = CW'(x);
    assign ye = CW'(y);

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (x == 0) && (y == 0);
        if (x < 0 && y >= 0)
        begin
            x_reg[0] <= ye;
            y_reg[0] <= -xe;
            z_reg[0] <= HALF_PI_Q16;
        end
        else if (x < 0)
        begin
            x_reg[0] <= -ye;
            y_reg[0] <= xe;
            z_reg[0] <= -HALF_PI_Q16;
        end
        else
        begin
            x_reg[0] <= xe;
            y_reg[0] <= ye;
            z_reg[0] <= '0;
        end
    end

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            logic signed [ZW-1:0] da;

            assign dx = y_reg[i] >>> i;
            assign dy = x_reg[i] >>> i;
            assign da = ZW'(ATAN_Q16[i]);

            always_ff @(posedge clk)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + da;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - da;
                end
            end
        end
    endgenerate

    logic signed [ZW-1:0] zr;

    assign zr = (z_reg[STEPS] + ZW'(8)) >>> 4;

    always_ff @(posedge clk)
    begin
        if (zero_reg[STEPS])
            angle_reg <= '0;
        else if (zr > PI_Q12)
            angle_reg <= ANGLE_W'(PI_Q12);
        else if (zr < -PI_Q12)
            angle_reg <= ANGLE_W'(-PI_Q12);
        else
            angle_reg <= zr[ANGLE_W-1:0];
    end

    assign angle = angle_reg;

endmodule

[rtl/core/swerve_drive_inverse_kinematics_top.sv]
// Top level of the four-wheel swerve drive inverse kinematics pipeline.
//
//  port group         direction  handshake         payload
//  request            in         start / busy      forward, lateral, rotation commands
//  result             out        done strobe       wheel0..3 speed and angle
//  configuration      in         cfg_write         cfg_index, cfg_data
//
// A request is taken every cycle; busy is always low. Each result appears
// after the front end stages and the lane stages, which hold the 28-bit
// square root done two bits per stage and the 16-step CORDIC done one step
// per stage. Reset clears the valid bits and restores the configuration
// registers. The receiver cannot stall, so the pipeline never holds.
module swerve_drive_inverse_kinematics_top
    import swd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [CMD_W-1:0]    forward_command,
    input  logic signed [CMD_W-1:0]    lateral_command,
    input  logic signed [CMD_W-1:0]    rotation_command,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    output logic                       done,
    output logic [SPEED_W-1:0]         wheel0_speed,
    output logic [SPEED_W-1:0]         wheel1_speed,
    output logic [SPEED_W-1:0]         wheel2_speed,
    output logic [SPEED_W-1:0]         wheel3_speed,
    output logic signed [ANGLE_W-1:0]  wheel0_angle,
    output logic signed [ANGLE_W-1:0]  wheel1_angle,
    output logic signed [ANGLE_W-1:0]  wheel2_angle,
    output logic signed [ANGLE_W-1:0]  wheel3_angle
);

    logic [THR_W-1:0]   thr_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [LATENCY-1:0] valid_reg;

    logic signed [CMD_W:0] vx_reg;
    logic signed [CMD_W:0] vy_reg;
    logic signed [CMD_W:0] w_reg;
    logic signed [CMD_W:0] vx2_reg;
    logic signed [CMD_W:0] vy2_reg;
    logic signed [XY_W-1:0] wk_reg;
    coord_t x_reg [WHEELS];
    coord_t y_reg [WHEELS];

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RESET;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DEADBAND: thr_reg   <= cfg_data[THR_W-1:0];
                REG_SCALE:    scale_reg <= cfg_data[SCALE_W-1:0];
                default:      thr_reg   <= thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LATENCY-2:0], accept};
    end

    assign done = valid_reg[LATENCY-1];

    // A value survives the deadband only if its magnitude reaches the threshold.
    function automatic logic signed [CMD_W:0] deadband(input logic signed [CMD_W:0] v,
                                                       input logic [THR_W-1:0] thr);
        logic [CMD_W:0] mag;
        mag = v < 0 ? -v : v;
        return ({1'b0, mag} >= {2'b0, thr}) ? v : '0;
    endfunction

    always_ff @(posedge clk)
    begin
        vx_reg  <= deadband((CMD_W+1)'(forward_command), thr_reg);
        vy_reg  <= -deadband((CMD_W+1)'(lateral_command), thr_reg);
        w_reg   <= deadband(-(CMD_W+1)'(rotation_command), thr_reg);
        wk_reg  <= XY_W'(w_reg) * XY_W'(signed'({1'b0, HALF_SQRT2_Q16}));
        vx2_reg <= vx_reg;
        vy2_reg <= vy_reg;
    end

    genvar k;
    generate
        for (k = 0; k < WHEELS; k++)
        begin : g_wheel
            coord_t bx;
            coord_t by;

            assign bx = XY_W'(vx2_reg) <<< 16;
            assign by = XY_W'(vy2_reg) <<< 16;

            always_ff @(posedge clk)
            begin
                x_reg[k] <= tan_x_neg(k) ? bx - wk_reg : bx + wk_reg;
                y_reg[k] <= tan_y_neg(k) ? by - wk_reg : by + wk_reg;
            end
        end
    endgenerate

    logic [SPEED_W-1:0]        speed [WHEELS];
    logic signed [ANGLE_W-1:0] angle [WHEELS];

    generate
        for (k = 0; k < WHEELS; k++)
        begin : g_lane
            swd_speed u_speed
            (
                .clk   (clk),
                .x     (x_reg[k]),
                .y     (y_reg[k]),
                .scale (scale_reg),
                .speed (speed[k])
            );

            swd_cordic u_cordic
            (
                .clk   (clk),
                .x     (x_reg[k]),
                .y     (y_reg[k]),
                .angle (angle[k])
            );
        end
    endgenerate

    assign wheel0_speed = speed[0];
    assign wheel1_speed = speed[1];
    assign wheel2_speed = speed[2];
    assign wheel3_speed = speed[3];
    assign wheel0_angle = angle[0];
    assign wheel1_angle = angle[1];
    assign wheel2_angle = angle[2];
    assign wheel3_angle = angle[3];

endmodule

[tb/swerve_drive_inverse_kinematics_top_test.sv]
// Self-checking testbench for the swerve drive inverse kinematics block.
`timescale 1ns / 1ps

module swerve_drive_inverse_kinematics_top_test;
    import swd_pkg::*;

    typedef struct packed {
        logic signed [CMD_W-1:0] fwd;
        logic signed [CMD_W-1:0] lat;
        logic signed [CMD_W-1:0] rot;
    } stick_t;

    typedef struct packed {
        logic [SPEED_W-1:0]        speed0, speed1, speed2, speed3;
        logic signed [ANGLE_W-1:0] angle0, angle1, angle2, angle3;
    } wheel_set_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CMD_W-1:0] forward_command = '0;
    logic signed [CMD_W-1:0] lateral_command = '0;
    logic signed [CMD_W-1:0] rotation_command = '0;
    logic cfg_write = 1'b0;
    logic cfg_index = REG_DEADBAND;
    logic [CFG_W-1:0] cfg_data = '0;
    logic done;
    logic [SPEED_W-1:0] wheel0_speed, wheel1_speed, wheel2_speed, wheel3_speed;
    logic signed [ANGLE_W-1:0] wheel0_angle, wheel1_angle, wheel2_angle, wheel3_angle;

    stick_t     pending_sticks[$];
    wheel_set_t expected_wheels[$];
    int         fail_count = 0;
    int         send_idle_pct = 0;
    bit         stimulus_done = 0;
    longint     model_threshold = THR_RESET;
    longint     model_scale = SCALE_RESET;

    swerve_drive_inverse_kinematics_top u_top (.*);

    always #2 clk = ~clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint apply_deadband(longint v);
        longint m;
        m = v < 0 ? -v : v;
        return m >= model_threshold ? v : 0;
    endfunction

    function automatic longint root_floor(longint v);
        longint r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [SPEED_W-1:0] speed_of(longint x, longint y);
        longint ax, ay, s;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        s = (root_floor(ax * ax + ay * ay) * model_scale + (64'd1 << 23)) >> 24;
        return s > 65535 ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic signed [ANGLE_W-1:0] heading_of(longint x, longint y);
        longint z, t, dx, dy;
        longint atans[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2};
        z = 0;
        if (x == 0 && y == 0) return '0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 102944;
            end
            else
            begin
                x = -y; y = t; z = -102944;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += atans[i];
            end
            else
            begin
                x -= dx; y += dy; z -= atans[i];
            end
        end
        z = floor_shift(z + 8, 4);
        if (z > 12868) z = 12868;
        if (z < -12868) z = -12868;
        return z[ANGLE_W-1:0];
    endfunction

    function automatic wheel_set_t solve_wheels(stick_t s);
        wheel_set_t r;
        longint vx, vy, w, x, y;
        logic [SPEED_W-1:0] sp[4];
        logic signed [ANGLE_W-1:0] an[4];
        vx = apply_deadband(longint'(s.fwd));
        vy = -apply_deadband(longint'(s.lat));
        w = apply_deadband(-longint'(s.rot)) * 46341;
        for (int i = 0; i < WHEELS; i++)
        begin
            x = vx * 65536 + (tan_x_neg(i) ? -w : w);
            y = vy * 65536 + (tan_y_neg(i) ? -w : w);
            sp[i] = speed_of(x, y);
            an[i] = heading_of(x, y);
        end
        r = '{sp[0], sp[1], sp[2], sp[3], an[0], an[1], an[2], an[3]};
        return r;
    endfunction

    // Driver: one request per accepted edge, gaps chosen at random.
    always @(negedge clk)
    begin
        stick_t s;
        if (rst_n && !cfg_write && pending_sticks.size() > 0 &&
            (!start || !busy) && $urandom_range(99) >= send_idle_pct)
        begin
            s = pending_sticks.pop_front();
            forward_command <= s.fwd;
            lateral_command <= s.lat;
            rotation_command <= s.rot;
            start <= 1'b1;
        end
        else if (!start || !busy)
            start <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (start && !busy)
            expected_wheels.push_back(solve_wheels(
                '{forward_command, lateral_command, rotation_command}));
    end

    always @(posedge clk)
    begin
        wheel_set_t got, want;
        if (done)
        begin
            got = '{wheel0_speed, wheel1_speed, wheel2_speed, wheel3_speed,
                    wheel0_angle, wheel1_angle, wheel2_angle, wheel3_angle};
            if (expected_wheels.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result %h", $realtime, got);
            end
            else
            begin
                want = expected_wheels.pop_front();
                if (got !== want) fail_count++;
                if (got.speed0 !== want.speed0)
                    $display("%0t speed0 exp %0d got %0d", $realtime, want.speed0, got.speed0);
                if (got.speed1 !== want.speed1)
                    $display("%0t speed1 exp %0d got %0d", $realtime, want.speed1, got.speed1);
                if (got.speed2 !== want.speed2)
                    $display("%0t speed2 exp %0d got %0d", $realtime, want.speed2, got.speed2);
                if (got.speed3 !== want.speed3)
                    $display("%0t speed3 exp %0d got %0d", $realtime, want.speed3, got.speed3);
                if (got.angle0 !== want.angle0)
                    $display("%0t angle0 exp %0d got %0d", $realtime, want.angle0, got.angle0);
                if (got.angle1 !== want.angle1)
                    $display("%0t angle1 exp %0d got %0d", $realtime, want.angle1, got.angle1);
                if (got.angle2 !== want.angle2)
                    $display("%0t angle2 exp %0d got %0d", $realtime, want.angle2, got.angle2);
                if (got.angle3 !== want.angle3)
                    $display("%0t angle3 exp %0d got %0d", $realtime, want.angle3, got.angle3);
            end
        end
    end

    task automatic wait_drained();
        while (pending_sticks.size() > 0 || start || expected_wheels.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_DEADBAND)
            model_threshold = value & 16'h7FF;
        else
            model_scale = value & 16'hFFFF;
    endtask

    function automatic logic signed [CMD_W-1:0] pick_stick();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 11'sh400 : 11'sh3FF;
            1: return $signed(11'($urandom_range(120))) - 11'sd60;
            default: return CMD_W'($urandom);
        endcase
    endfunction

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            pending_sticks.push_back('{pick_stick(), pick_stick(), pick_stick()});
    endtask

    initial
    begin
        int thresholds[5] = '{0, 1024, 1025, 2047, 300};
        int scales[5] = '{65535, 0, 1, 40000, 852};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // Extremes, deadband edges, axis directions and the zero vector.
        pending_sticks.push_back('{11'sd0, 11'sd0, 11'sd0});
        pending_sticks.push_back('{11'sh400, 11'sh400, 11'sh400});
        pending_sticks.push_back('{11'sh3FF, 11'sh3FF, 11'sh3FF});
        pending_sticks.push_back('{11'sd50, 11'sd49, -11'sd50});
        pending_sticks.push_back('{-11'sd49, -11'sd50, 11'sd49});
        pending_sticks.push_back('{-11'sd500, 11'sd0, 11'sd0});
        pending_sticks.push_back('{11'sd500, 11'sd0, 11'sd0});
        pending_sticks.push_back('{11'sd0, 11'sd500, 11'sd0});
        pending_sticks.push_back('{11'sd0, -11'sd500, 11'sd0});
        pending_sticks.push_back('{11'sd0, 11'sd0, 11'sh400});
        pending_sticks.push_back('{-11'sd300, 11'sd300, 11'sd300});
        pending_sticks.push_back('{11'sh7FF, 11'sd1, -11'sd1});
        wait_drained();
        for (int p = 0; p < 5; p++)
        begin
            write_reg(REG_DEADBAND, thresholds[p]);
            write_reg(REG_SCALE, scales[p]);
            send_idle_pct = (p == 1 || p == 3) ? 66 : (p == 2 ? 8 : 0);
            pending_sticks.push_back('{11'sh400, 11'sh400, 11'sh400});
            pending_sticks.push_back('{11'sd0, 11'sd0, 11'sh400});
            queue_random(p == 4 ? 350 : 150);
            wait_drained();
        end
        stimulus_done = 1;
    end

    initial
    begin
        wait (stimulus_done);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
